// ===== sv/cmjd_pkg.sv =====
package cmjd_pkg;

    // sizing of the machine table, the job table and the counters
    localparam int NUM_MACHINES = 8;
    localparam int MACH_W       = 3;
    localparam int CAP_BITS     = 16;
    localparam int NUM_JOBS     = 256;
    localparam int JOB_W        = 8;
    localparam int COUNT_BITS   = 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // operation codes carried on the input tuser
    localparam logic [1:0] MODE_REGISTER = 2'd0;
    localparam logic [1:0] MODE_ASSIGN   = 2'd1;
    localparam logic [1:0] MODE_COMPLETE = 2'd2;

    // selection criterion code for most finished jobs
    localparam logic [1:0] CRIT_MOST_DONE = 2'd1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REGISTER,
        ST_SCAN,
        ST_ASSIGN,
        ST_OWNER_RD,
        ST_COMPLETE,
        ST_DONE
    } state_t;

    // one machine slot as seen by the shared compare unit
    typedef struct packed {
        logic                  present;
        logic [CAP_BITS-1:0]   caps;
        logic [COUNT_BITS-1:0] cnt;
    } cand_t;

endpackage

// ===== sv/cmjd_pick_unit.sv =====
module cmjd_pick_unit
    import cmjd_pkg::*;
(
    input  cand_t                 cand,
    input  logic [CAP_BITS-1:0]   need,
    input  logic [COUNT_BITS-1:0] best_cnt,
    input  logic                  have_best,
    input  logic                  by_done,
    output logic                  take
);

    logic                  covers;
    logic [COUNT_BITS-1:0] cmp_a;
    logic [COUNT_BITS-1:0] cmp_b;
    logic                  better;

    // capability cover check
    assign covers = ((cand.caps & need) == need);

    // one magnitude comparator, operands swapped for most finished
    always_comb begin
        if (by_done) begin
            cmp_a = best_cnt;
            cmp_b = cand.cnt;
        end else begin
            cmp_a = cand.cnt;
            cmp_b = best_cnt;
        end
    end

    assign better = (cmp_a < cmp_b);

    // strict compare keeps ties on the lower index
    assign take = cand.present && covers && (!have_best || better);

endmodule

// ===== sv/capability_matched_job_dispatcher_top.sv =====
// channel   | ports      | tdata (low bit up)                                  | tuser
// ----------+------------+-----------------------------------------------------+-------------
// request   | s_axis_*   | machine_slot[2:0] cap_mask[18:3] job_slot[26:19]     | mode[1:0]
//           |            | criterion[28:27], zero to bit 31                    |
// result    | m_axis_*   | chosen_machine[2:0], zero to bit 7                  | found
//
// one transaction at a time: after acceptance, register passes through its update step,
// complete through a registered read of the job owner memory and an update step, an unknown
// mode goes straight to hand-off, and assign scans the eight slots through one shared compare
// unit, then a read-modify-write; each ends at hand-off, and idle then takes the next request
// aresetn is synchronous, active low; it clears valid bits, counters and the sequencer
// a waiting result only holds the sequencer at its hand-off step until it is taken
module capability_matched_job_dispatcher_top
    import cmjd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // machine_slot, cap_mask, job_slot, criterion, padding
    input  logic [31:0] s_axis_tdata,
    // mode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // chosen_machine, padding
    output logic [7:0]  m_axis_tdata,
    // found
    output logic        m_axis_tuser
);

    state_t state_reg;
    state_t state_next;

    logic s_accept;
    logic load_out;

    // latched request
    logic [MACH_W-1:0]   slot_reg;
    logic [CAP_BITS-1:0] need_reg;
    logic [JOB_W-1:0]    job_reg;
    logic [1:0]          crit_reg;

    // machine table
    logic [NUM_MACHINES-1:0] present_reg;
    logic [CAP_BITS-1:0]     caps_reg [NUM_MACHINES];
    logic [COUNT_BITS-1:0]   open_reg [NUM_MACHINES];
    logic [COUNT_BITS-1:0]   done_reg [NUM_MACHINES];

    // job table
    logic [NUM_JOBS-1:0] job_known_reg;
    logic [MACH_W-1:0]   owner_mem [NUM_JOBS];
    logic [MACH_W-1:0]   owner_rd_reg;

    // scan state
    logic [MACH_W-1:0]     scan_idx_reg;
    logic [MACH_W-1:0]     best_idx_reg;
    logic [COUNT_BITS-1:0] best_cnt_reg;
    logic                  have_best_reg;

    // pending result and output register
    logic              res_found_reg;
    logic [MACH_W-1:0] res_mach_reg;
    logic              m_valid_reg;
    logic              m_found_reg;
    logic [MACH_W-1:0] m_mach_reg;

    cand_t cand;
    logic  by_done;
    logic  take;
    logic  owner_wr;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign by_done  = (crit_reg == CRIT_MOST_DONE);
    assign owner_wr = (state_reg == ST_ASSIGN) && have_best_reg;

    // candidate presented to the shared compare unit
    always_comb begin
        cand.present = present_reg[scan_idx_reg];
        cand.caps    = caps_reg[scan_idx_reg];
        cand.cnt     = by_done ? done_reg[scan_idx_reg] : open_reg[scan_idx_reg];
    end

    cmjd_pick_unit u_pick (
        .cand      (cand),
        .need      (need_reg),
        .best_cnt  (best_cnt_reg),
        .have_best (have_best_reg),
        .by_done   (by_done),
        .take      (take)
    );

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and handshake
    always_comb begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    unique case (s_axis_tuser)
                        MODE_REGISTER: state_next = ST_REGISTER;
                        MODE_ASSIGN:   state_next = ST_SCAN;
                        MODE_COMPLETE: state_next = ST_OWNER_RD;
                        default:       state_next = ST_DONE;
                    endcase
                end
            end
            ST_REGISTER: state_next = ST_DONE;
            ST_SCAN: begin
                if (scan_idx_reg == MACH_W'(NUM_MACHINES - 1)) begin
                    state_next = ST_ASSIGN;
                end
            end
            ST_ASSIGN:   state_next = ST_DONE;
            ST_OWNER_RD: state_next = ST_COMPLETE;
            ST_COMPLETE: state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // valid bits, counters and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg   <= '0;
            job_known_reg <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_MACHINES; i++) begin
                open_reg[i] <= '0;
                done_reg[i] <= '0;
            end
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_REGISTER: begin
                    present_reg[slot_reg] <= 1'b1;
                    open_reg[slot_reg]    <= '0;
                    done_reg[slot_reg]    <= '0;
                end
                ST_ASSIGN: begin
                    if (have_best_reg) begin
                        job_known_reg[job_reg] <= 1'b1;
                        if (open_reg[best_idx_reg] != COUNT_MAX) begin
                            open_reg[best_idx_reg] <= open_reg[best_idx_reg] + 1'b1;
                        end
                    end
                end
                ST_COMPLETE: begin
                    if (job_known_reg[job_reg]) begin
                        if (open_reg[owner_rd_reg] != '0) begin
                            open_reg[owner_rd_reg] <= open_reg[owner_rd_reg] - 1'b1;
                        end
                        if (done_reg[owner_rd_reg] != COUNT_MAX) begin
                            done_reg[owner_rd_reg] <= done_reg[owner_rd_reg] + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // job owner memory, registered read
    always_ff @(posedge aclk) begin
        if (owner_wr) begin
            owner_mem[job_reg] <= best_idx_reg;
        end
        owner_rd_reg <= owner_mem[job_reg];
    end

    // request latch, scan and result payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            slot_reg      <= s_axis_tdata[2:0];
            need_reg      <= s_axis_tdata[18:3];
            job_reg       <= s_axis_tdata[26:19];
            crit_reg      <= s_axis_tdata[28:27];
            scan_idx_reg  <= '0;
            have_best_reg <= 1'b0;
            res_found_reg <= 1'b0;
            res_mach_reg  <= '0;
        end
        unique case (state_reg)
            ST_REGISTER: begin
                caps_reg[slot_reg] <= need_reg;
                res_found_reg      <= 1'b1;
                res_mach_reg       <= slot_reg;
            end
            ST_SCAN: begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (take) begin
                    best_idx_reg  <= scan_idx_reg;
                    best_cnt_reg  <= cand.cnt;
                    have_best_reg <= 1'b1;
                end
            end
            ST_ASSIGN: begin
                if (have_best_reg) begin
                    res_found_reg <= 1'b1;
                    res_mach_reg  <= best_idx_reg;
                end
            end
            ST_COMPLETE: begin
                if (job_known_reg[job_reg]) begin
                    res_found_reg <= 1'b1;
                    res_mach_reg  <= owner_rd_reg;
                end
            end
            default: begin
            end
        endcase
        if (load_out) begin
            m_found_reg <= res_found_reg;
            m_mach_reg  <= res_mach_reg;
        end
    end

    // result channel
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_found_reg;
    assign m_axis_tdata  = {{(8 - MACH_W){1'b0}}, m_mach_reg};

endmodule

// ===== sv/cmjd_checker.sv =====
module cmjd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tuser
);

    // no result straight out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // the block is busy in the cycle after taking a request
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while still busy");

    // a failed operation reports machine zero
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 8'd0))
        else $error("machine index on a failed result");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind capability_matched_job_dispatcher_top cmjd_checker u_cmjd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
